>>> src/vrt_pkg.sv
`default_nettype none
package vrt_pkg;

  localparam int unsigned WEIGHT_BITS        = 16;
  localparam int unsigned MSTEP_BITS         = 7;
  localparam int unsigned CFG_IDX_BITS       = 3;
  localparam int unsigned DEF_MAX_STEP_LIMIT = 64;
  localparam int unsigned DEF_KEY_BITS       = 16;
  localparam int unsigned Q_DEPTH            = 2;

  localparam int RST_LOW_X     = 0;
  localparam int RST_HIGH_X    = 255;
  localparam int RST_LOW_Y     = 0;
  localparam int RST_HIGH_Y    = 255;
  localparam int RST_LOW_Z     = 0;
  localparam int RST_HIGH_Z    = 63;
  localparam int RST_MAX_STEPS = 64;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_LOW_X     = 3'd0,
    CFG_HIGH_X    = 3'd1,
    CFG_LOW_Y     = 3'd2,
    CFG_HIGH_Y    = 3'd3,
    CFG_LOW_Z     = 3'd4,
    CFG_HIGH_Z    = 3'd5,
    CFG_MAX_STEPS = 3'd6
  } cfg_idx_t;

  // queue status seen by the front and back ends
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage
`default_nettype wire

>>> src/vrt_front.sv
`default_nettype none
module vrt_front #(
  parameter int unsigned KEY_BITS       = vrt_pkg::DEF_KEY_BITS,
  parameter int unsigned MAX_STEP_LIMIT = vrt_pkg::DEF_MAX_STEP_LIMIT,
  parameter int unsigned DW             = 1
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [KEY_BITS-1:0]              in_origin_x,
  input  wire logic [KEY_BITS-1:0]              in_origin_y,
  input  wire logic [KEY_BITS-1:0]              in_origin_z,
  input  wire logic [KEY_BITS-1:0]              in_end_x,
  input  wire logic [KEY_BITS-1:0]              in_end_y,
  input  wire logic [KEY_BITS-1:0]              in_end_z,
  input  wire logic                             in_stop_at_end,
  input  wire logic [vrt_pkg::WEIGHT_BITS-1:0]  in_weight,
  input  wire logic [vrt_pkg::MSTEP_BITS-1:0]   max_steps,
  input  wire vrt_pkg::q_stat_t                 q_stat,
  output logic                                  q_push,
  output logic [DW-1:0]                         q_push_data
);
  import vrt_pkg::*;

  localparam int unsigned CW = KEY_BITS + 1;
  localparam int unsigned LW = $clog2(MAX_STEP_LIMIT + 1);

  typedef struct packed {
    logic [2:0][KEY_BITS-1:0] org;
    logic [2:0][KEY_BITS-1:0] tgt;
    logic [2:0][KEY_BITS-1:0] ad;
    logic [2:0]               neg;
    logic [2:0]               nz;
    logic                     stop;
    logic [WEIGHT_BITS-1:0]   weight;
    logic [LW-1:0]            lim;
  } ray_t;

  logic                     f_valid_r, f_valid_nxt;
  logic [2:0][KEY_BITS-1:0] org_r, tgt_r;
  logic                     stop_r;
  logic [WEIGHT_BITS-1:0]   weight_r;
  logic                     accept;
  logic [LW-1:0]            ms_sat;
  ray_t                     ray;

  assign busy   = f_valid_r && q_stat.full;
  assign accept = start && !busy;
  assign q_push = f_valid_r && !q_stat.full;

  always_comb begin
    f_valid_nxt = f_valid_r;
    if (accept) begin
      f_valid_nxt = 1'b1;
    end else if (q_push) begin
      f_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else begin
      f_valid_r <= f_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      org_r    <= {in_origin_z, in_origin_y, in_origin_x};
      tgt_r    <= {in_end_z, in_end_y, in_end_x};
      stop_r   <= in_stop_at_end;
      weight_r <= in_weight;
    end
  end

  // direction sign and magnitude per axis, step limit saturated
  always_comb begin
    logic signed [CW-1:0] d;
    logic        [CW-1:0] mag;
    ray.org    = org_r;
    ray.tgt    = tgt_r;
    ray.stop   = stop_r;
    ray.weight = weight_r;
    for (int a = 0; a < 3; a++) begin
      d = $signed({tgt_r[a][KEY_BITS-1], tgt_r[a]}) - $signed({org_r[a][KEY_BITS-1], org_r[a]});
      mag = d[CW-1] ? CW'(-d) : d;
      ray.neg[a] = d[CW-1];
      ray.nz[a]  = (d != '0);
      ray.ad[a]  = mag[KEY_BITS-1:0];
    end
    if (max_steps > MSTEP_BITS'(MAX_STEP_LIMIT)) begin
      ms_sat = LW'(MAX_STEP_LIMIT);
    end else begin
      ms_sat = max_steps[LW-1:0];
    end
    ray.lim = (ray.nz == 3'b000) ? '0 : ms_sat;
  end

  assign q_push_data = ray;

endmodule
`default_nettype wire

>>> src/vrt_queue.sv
`default_nettype none
module vrt_queue #(
  parameter int unsigned DW = 1
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [DW-1:0]    push_data,
  input  wire logic             pop,
  output logic [DW-1:0]         pop_data,
  output vrt_pkg::q_stat_t      q_stat
);
  import vrt_pkg::*;

  localparam int unsigned PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(Q_DEPTH + 1);

  logic [DW-1:0]    entry_r [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign q_stat.full  = (cnt_r == CNT_W'(Q_DEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign pop_data     = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

>>> src/vrt_back.sv
`default_nettype none
module vrt_back #(
  parameter int unsigned KEY_BITS       = vrt_pkg::DEF_KEY_BITS,
  parameter int unsigned MAX_STEP_LIMIT = vrt_pkg::DEF_MAX_STEP_LIMIT,
  parameter int unsigned DW             = 1
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire vrt_pkg::q_stat_t                 q_stat,
  input  wire logic [DW-1:0]                    q_data,
  output logic                                  q_pop,
  input  wire logic [2:0][KEY_BITS:0]           bnd_lo,
  input  wire logic [2:0][KEY_BITS:0]           bnd_hi,
  output logic                                  out_valid,
  output logic [KEY_BITS-1:0]                   out_voxel_x,
  output logic [KEY_BITS-1:0]                   out_voxel_y,
  output logic [KEY_BITS-1:0]                   out_voxel_z,
  output logic [vrt_pkg::WEIGHT_BITS-1:0]       out_voxel_weight,
  output logic                                  out_last,
  output logic                                  out_empty_res
);
  import vrt_pkg::*;

  localparam int unsigned CW = KEY_BITS + 1;
  localparam int unsigned LW = $clog2(MAX_STEP_LIMIT + 1);
  localparam int unsigned MW = $clog2(2 * MAX_STEP_LIMIT + 2);
  localparam int unsigned PW = KEY_BITS + MW;

  typedef struct packed {
    logic [2:0][KEY_BITS-1:0] org;
    logic [2:0][KEY_BITS-1:0] tgt;
    logic [2:0][KEY_BITS-1:0] ad;
    logic [2:0]               neg;
    logic [2:0]               nz;
    logic                     stop;
    logic [WEIGHT_BITS-1:0]   weight;
    logic [LW-1:0]            lim;
  } ray_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } state_t;

  ray_t ray_in;

  state_t                   state_r, state_nxt;
  logic [2:0][CW-1:0]       c_r, c_nxt;
  logic [2:0][KEY_BITS-1:0] tgt_r, tgt_nxt;
  logic [2:0][KEY_BITS-1:0] ad_r, ad_nxt;
  logic [2:0]               neg_r, neg_nxt;
  logic [2:0]               nz_r, nz_nxt;
  logic                     stop_r, stop_nxt;
  logic [WEIGHT_BITS-1:0]   w_r, w_nxt;
  logic [LW-1:0]            lim_r, lim_nxt;
  logic [LW-1:0]            cnt_r, cnt_nxt;
  // crossing products: pAB = (2*kA + 1) * |dB|
  logic [PW-1:0]            p01_r, p01_nxt, p02_r, p02_nxt;
  logic [PW-1:0]            p10_r, p10_nxt, p12_r, p12_nxt;
  logic [PW-1:0]            p20_r, p20_nxt, p21_r, p21_nxt;
  logic                     pend_valid_r, pend_valid_nxt;
  logic [2:0][KEY_BITS-1:0] pend_r, pend_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic [2:0][KEY_BITS-1:0] out_key_r, out_key_nxt;
  logic [WEIGHT_BITS-1:0]   out_w_r, out_w_nxt;
  logic                     out_last_r, out_last_nxt;
  logic                     out_empty_r, out_empty_nxt;

  logic                     lt10, lt20, lt21, take1, take2;
  logic [2:0]               sel;
  logic [2:0][CW-1:0]       c_new;
  logic                     inb, at_end, step_ok;
  logic [PW-1:0]            ad2_0, ad2_1, ad2_2;

  assign ray_in = q_data;
  assign q_pop  = (state_r == S_IDLE) && !q_stat.empty;

  assign ad2_0 = PW'({ad_r[0], 1'b0});
  assign ad2_1 = PW'({ad_r[1], 1'b0});
  assign ad2_2 = PW'({ad_r[2], 1'b0});

  // axis choice: strictly nearer crossing wins, lower axis on ties
  always_comb begin
    lt10  = p10_r < p01_r;
    lt20  = p20_r < p02_r;
    lt21  = p21_r < p12_r;
    take1 = nz_r[1] && (!nz_r[0] || lt10);
    take2 = nz_r[2] && (!(nz_r[0] || nz_r[1]) || (take1 ? lt21 : lt20));
    sel[2] = take2;
    sel[1] = take1 && !take2;
    sel[0] = nz_r[0] && !take1 && !take2;
  end

  always_comb begin
    inb    = 1'b1;
    at_end = 1'b1;
    for (int a = 0; a < 3; a++) begin
      c_new[a] = sel[a] ? c_r[a] + {{(CW-1){neg_r[a]}}, 1'b1} : c_r[a];
      if ($signed(c_new[a]) < $signed(bnd_lo[a]) || $signed(c_new[a]) > $signed(bnd_hi[a])) begin
        inb = 1'b0;
      end
      if (c_new[a] != {tgt_r[a][KEY_BITS-1], tgt_r[a]}) begin
        at_end = 1'b0;
      end
    end
    step_ok = (sel != 3'b000) && (cnt_r != lim_r) && inb && !(stop_r && at_end);
  end

  always_comb begin
    state_nxt      = state_r;
    c_nxt          = c_r;
    tgt_nxt        = tgt_r;
    ad_nxt         = ad_r;
    neg_nxt        = neg_r;
    nz_nxt         = nz_r;
    stop_nxt       = stop_r;
    w_nxt          = w_r;
    lim_nxt        = lim_r;
    cnt_nxt        = cnt_r;
    p01_nxt        = p01_r;
    p02_nxt        = p02_r;
    p10_nxt        = p10_r;
    p12_nxt        = p12_r;
    p20_nxt        = p20_r;
    p21_nxt        = p21_r;
    pend_valid_nxt = pend_valid_r;
    pend_nxt       = pend_r;
    out_valid_nxt  = 1'b0;
    out_key_nxt    = out_key_r;
    out_w_nxt      = out_w_r;
    out_last_nxt   = out_last_r;
    out_empty_nxt  = out_empty_r;
    unique case (state_r)
      S_IDLE: begin
        if (q_pop) begin
          for (int a = 0; a < 3; a++) begin
            c_nxt[a] = {ray_in.org[a][KEY_BITS-1], ray_in.org[a]};
          end
          tgt_nxt        = ray_in.tgt;
          ad_nxt         = ray_in.ad;
          neg_nxt        = ray_in.neg;
          nz_nxt         = ray_in.nz;
          stop_nxt       = ray_in.stop;
          w_nxt          = ray_in.weight;
          lim_nxt        = ray_in.lim;
          cnt_nxt        = '0;
          p01_nxt        = PW'(ray_in.ad[1]);
          p02_nxt        = PW'(ray_in.ad[2]);
          p10_nxt        = PW'(ray_in.ad[0]);
          p12_nxt        = PW'(ray_in.ad[2]);
          p20_nxt        = PW'(ray_in.ad[0]);
          p21_nxt        = PW'(ray_in.ad[1]);
          pend_valid_nxt = 1'b0;
          state_nxt      = S_RUN;
        end
      end
      S_RUN: begin
        if (step_ok) begin
          // previous voxel goes out, the new one waits to learn if it is last
          c_nxt          = c_new;
          cnt_nxt        = cnt_r + 1'b1;
          pend_valid_nxt = 1'b1;
          for (int a = 0; a < 3; a++) begin
            pend_nxt[a] = c_new[a][KEY_BITS-1:0];
          end
          if (sel[0]) begin
            p01_nxt = p01_r + ad2_1;
            p02_nxt = p02_r + ad2_2;
          end
          if (sel[1]) begin
            p10_nxt = p10_r + ad2_0;
            p12_nxt = p12_r + ad2_2;
          end
          if (sel[2]) begin
            p20_nxt = p20_r + ad2_0;
            p21_nxt = p21_r + ad2_1;
          end
          if (pend_valid_r) begin
            out_valid_nxt = 1'b1;
            out_key_nxt   = pend_r;
            out_w_nxt     = w_r;
            out_last_nxt  = 1'b0;
            out_empty_nxt = 1'b0;
          end
        end else begin
          out_valid_nxt  = 1'b1;
          out_last_nxt   = 1'b1;
          pend_valid_nxt = 1'b0;
          if (pend_valid_r) begin
            out_key_nxt   = pend_r;
            out_w_nxt     = w_r;
            out_empty_nxt = 1'b0;
          end else begin
            out_key_nxt   = '0;
            out_w_nxt     = '0;
            out_empty_nxt = 1'b1;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      cnt_r        <= '0;
      lim_r        <= '0;
    end else begin
      state_r      <= state_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      cnt_r        <= cnt_nxt;
      lim_r        <= lim_nxt;
    end
  end

  always_ff @(posedge clk) begin
    c_r         <= c_nxt;
    tgt_r       <= tgt_nxt;
    ad_r        <= ad_nxt;
    neg_r       <= neg_nxt;
    nz_r        <= nz_nxt;
    stop_r      <= stop_nxt;
    w_r         <= w_nxt;
    p01_r       <= p01_nxt;
    p02_r       <= p02_nxt;
    p10_r       <= p10_nxt;
    p12_r       <= p12_nxt;
    p20_r       <= p20_nxt;
    p21_r       <= p21_nxt;
    pend_r      <= pend_nxt;
    out_key_r   <= out_key_nxt;
    out_w_r     <= out_w_nxt;
    out_last_r  <= out_last_nxt;
    out_empty_r <= out_empty_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_voxel_x      = out_key_r[0];
  assign out_voxel_y      = out_key_r[1];
  assign out_voxel_z      = out_key_r[2];
  assign out_voxel_weight = out_w_r;
  assign out_last         = out_last_r;
  assign out_empty_res    = out_empty_r;

  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_empty_r) |-> out_last_r)
    else $error("empty result not marked last");

  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN) |-> (cnt_r <= lim_r))
    else $error("step count beyond limit");

  a_pend_has_step: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r |-> (cnt_r != '0))
    else $error("pending voxel without a step");

  a_ray_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN && state_nxt == S_IDLE) |=> (out_valid_r && out_last_r))
    else $error("ray finished without a last result");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (state_r == S_IDLE && !q_stat.empty))
    else $error("queue popped while busy or empty");

endmodule
`default_nettype wire

>>> src/voxel_ray_traversal_3d.sv
`default_nettype none
// 3-D voxel ray walker.
// Input: a ray (origin key, end key, stop_at_end, weight) is accepted at a
// rising edge with start high and busy low. busy rises only when the input
// holding register and the two-entry ray queue are both full.
// Output: one transaction per visited voxel, out_valid high for one cycle;
// the receiver cannot stall. out_last marks the final voxel of a ray; a ray
// that visits nothing gives one transaction with out_empty_res and out_last
// set and zero key/weight.
// Flow: an accepted ray passes the input holding register and the ray queue
// into the stepping unit; voxels of a ray then come out one per cycle.
// Per ray: load, one step per voxel, one closing step, then idle to pop the next.
// The stepping unit takes one step per cycle: a 3-way compare of
// incrementally kept crossing products, then a key update and bounds check.
// Config: write cfg_index/cfg_data with cfg_valid (cfg_ready is always high),
// only while no ray is in flight. Index 7 is ignored.
// Reset: synchronous active-low rst_n empties the queue, idles the walker and
// loads bounds x 0..255, y 0..255, z 0..63 and max_steps 64.
module voxel_ray_traversal_3d #(
  parameter int unsigned KEY_BITS       = vrt_pkg::DEF_KEY_BITS,
  parameter int unsigned MAX_STEP_LIMIT = vrt_pkg::DEF_MAX_STEP_LIMIT
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [KEY_BITS-1:0]              in_origin_x,
  input  wire logic [KEY_BITS-1:0]              in_origin_y,
  input  wire logic [KEY_BITS-1:0]              in_origin_z,
  input  wire logic [KEY_BITS-1:0]              in_end_x,
  input  wire logic [KEY_BITS-1:0]              in_end_y,
  input  wire logic [KEY_BITS-1:0]              in_end_z,
  input  wire logic                             in_stop_at_end,
  input  wire logic [vrt_pkg::WEIGHT_BITS-1:0]  in_weight,
  output logic                                  out_valid,
  output logic [KEY_BITS-1:0]                   out_voxel_x,
  output logic [KEY_BITS-1:0]                   out_voxel_y,
  output logic [KEY_BITS-1:0]                   out_voxel_z,
  output logic [vrt_pkg::WEIGHT_BITS-1:0]       out_voxel_weight,
  output logic                                  out_last,
  output logic                                  out_empty_res,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [vrt_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [KEY_BITS-1:0]              cfg_data
);
  import vrt_pkg::*;

  localparam int unsigned BW = KEY_BITS + 1;
  localparam int unsigned LW = $clog2(MAX_STEP_LIMIT + 1);
  localparam int unsigned DW = 9 * KEY_BITS + 7 + WEIGHT_BITS + LW;

  logic [2:0][BW-1:0]       lo_r, hi_r;
  logic [MSTEP_BITS-1:0]    max_steps_r;
  logic [BW-1:0]            cfg_key;

  q_stat_t                  q_stat;
  logic                     q_push, q_pop;
  logic [DW-1:0]            q_push_data, q_data;

  assign cfg_ready = 1'b1;
  assign cfg_key   = {cfg_data[KEY_BITS-1], cfg_data};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_r[0]     <= BW'(RST_LOW_X);
      hi_r[0]     <= BW'(RST_HIGH_X);
      lo_r[1]     <= BW'(RST_LOW_Y);
      hi_r[1]     <= BW'(RST_HIGH_Y);
      lo_r[2]     <= BW'(RST_LOW_Z);
      hi_r[2]     <= BW'(RST_HIGH_Z);
      max_steps_r <= MSTEP_BITS'(RST_MAX_STEPS);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_LOW_X:     lo_r[0]     <= cfg_key;
        CFG_HIGH_X:    hi_r[0]     <= cfg_key;
        CFG_LOW_Y:     lo_r[1]     <= cfg_key;
        CFG_HIGH_Y:    hi_r[1]     <= cfg_key;
        CFG_LOW_Z:     lo_r[2]     <= cfg_key;
        CFG_HIGH_Z:    hi_r[2]     <= cfg_key;
        CFG_MAX_STEPS: max_steps_r <= cfg_data[MSTEP_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  vrt_front #(
    .KEY_BITS       (KEY_BITS),
    .MAX_STEP_LIMIT (MAX_STEP_LIMIT),
    .DW             (DW)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_origin_x    (in_origin_x),
    .in_origin_y    (in_origin_y),
    .in_origin_z    (in_origin_z),
    .in_end_x       (in_end_x),
    .in_end_y       (in_end_y),
    .in_end_z       (in_end_z),
    .in_stop_at_end (in_stop_at_end),
    .in_weight      (in_weight),
    .max_steps      (max_steps_r),
    .q_stat         (q_stat),
    .q_push         (q_push),
    .q_push_data    (q_push_data)
  );

  vrt_queue #(
    .DW (DW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .pop_data  (q_data),
    .q_stat    (q_stat)
  );

  vrt_back #(
    .KEY_BITS       (KEY_BITS),
    .MAX_STEP_LIMIT (MAX_STEP_LIMIT),
    .DW             (DW)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_stat           (q_stat),
    .q_data           (q_data),
    .q_pop            (q_pop),
    .bnd_lo           (lo_r),
    .bnd_hi           (hi_r),
    .out_valid        (out_valid),
    .out_voxel_x      (out_voxel_x),
    .out_voxel_y      (out_voxel_y),
    .out_voxel_z      (out_voxel_z),
    .out_voxel_weight (out_voxel_weight),
    .out_last         (out_last),
    .out_empty_res    (out_empty_res)
  );

endmodule
`default_nettype wire
